// ===== src/kmeans_bound_update_unit_defines.svh =====
// Assertion macros shared by the bound update unit RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef KMEANS_BOUND_UPDATE_UNIT_DEFINES_SVH
`define KMEANS_BOUND_UPDATE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KBU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("kbu assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KBU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("kbu assertion failed");

`endif

// ===== src/kbu_pkg.sv =====
// Shared constants and types for the k-means bound update unit.
// No dependencies; used by the interfaces and by all modules except kbu_ram.
package kbu_pkg;

	localparam int FIELD_W          = 32;
	localparam int IDX_W_IN         = 4;
	localparam int NCL_W            = 5;
	localparam int MAX_CLUSTERS_DEF = 16;
	localparam int VALUE_WIDTH_DEF  = 32;
	localparam int QUEUE_DEPTH      = 2;

	localparam logic [NCL_W-1:0] NUM_CLUSTERS_RST = 5'd16;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	// What the front end decided about a queued transaction.
	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_UPDATE = 2'd1,
		CMD_REJECT = 2'd2
	} kbu_kind_t;

	typedef struct packed {
		kbu_kind_t             kind;
		logic [IDX_W_IN-1:0]   idx;
	} kbu_ctl_t;

endpackage

// ===== src/kbu_in_if.sv =====
// Input channel of the bound update unit: valid/ready plus one item.
// Depends on kbu_pkg for field widths.
interface kbu_in_if;
	import kbu_pkg::*;

	logic                valid;
	logic                ready;
	logic                operation;
	logic [IDX_W_IN-1:0] cluster_index;
	logic [FIELD_W-1:0]  moved_distance;
	logic [FIELD_W-1:0]  upper_bound;
	logic [FIELD_W-1:0]  lower_bound;

	modport source (
		output valid, operation, cluster_index, moved_distance, upper_bound, lower_bound,
		input  ready
	);

	modport sink (
		input  valid, operation, cluster_index, moved_distance, upper_bound, lower_bound,
		output ready
	);
endinterface

// ===== src/kbu_out_if.sv =====
// Result channel of the bound update unit: valid/ready plus updated bounds.
// Depends on kbu_pkg for field widths.
interface kbu_out_if;
	import kbu_pkg::*;

	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] new_upper;
	logic [FIELD_W-1:0] new_lower;
	logic               label_error;

	modport source (
		output valid, new_upper, new_lower, label_error,
		input  ready
	);

	modport sink (
		input  valid, new_upper, new_lower, label_error,
		output ready
	);
endinterface

// ===== src/kmeans_bound_update_unit.sv =====
// Top level of the k-means bound update unit: front end, back end and their queue link.
// Depends on kbu_pkg, kbu_in_if, kbu_out_if, kbu_front and kbu_back.
//
// Load transactions (operation 0) write one cluster's center movement into the table and
// update the running largest and second-largest movement; a load at cluster zero restarts
// that tracking. Point transactions (operation 1) return the upper bound plus the point's own
// cluster movement, saturated, and the absolute difference between the lower bound and the
// largest movement of any other cluster; a label at or above num_clusters returns the bounds
// unchanged with label_error set. The unit takes one transaction per clock when the result
// side keeps up: loads retire in the cycle they leave the two-entry command queue, and a point
// is registered in the read stage, which uses the single read port of the movement table and
// its registered read, then in the output register. Write num_clusters (cfg_we/cfg_wdata)
// only while the unit is idle.
module kmeans_bound_update_unit #(
	parameter int MAX_CLUSTERS = kbu_pkg::MAX_CLUSTERS_DEF,
	parameter int VALUE_WIDTH  = kbu_pkg::VALUE_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	kbu_in_if.sink                    cmd,
	kbu_out_if.source                 res,
	input  logic                      cfg_we,
	input  logic [kbu_pkg::NCL_W-1:0] cfg_wdata
);
	import kbu_pkg::*;

	logic                   q_valid;
	logic                   q_ready;
	kbu_ctl_t               q_ctl;
	logic [VALUE_WIDTH-1:0] q_moved;
	logic [VALUE_WIDTH-1:0] q_upper;
	logic [VALUE_WIDTH-1:0] q_lower;

	kbu_front #(
		.MAX_CLUSTERS (MAX_CLUSTERS),
		.VALUE_WIDTH  (VALUE_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_ctl     (q_ctl),
		.q_moved   (q_moved),
		.q_upper   (q_upper),
		.q_lower   (q_lower)
	);

	kbu_back #(
		.MAX_CLUSTERS (MAX_CLUSTERS),
		.VALUE_WIDTH  (VALUE_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_ctl   (q_ctl),
		.q_moved (q_moved),
		.q_upper (q_upper),
		.q_lower (q_lower),
		.res     (res)
	);
endmodule

// ===== src/kbu_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module kbu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== src/kbu_front.sv =====
// Front end: cluster count register, item classification and the command queue.
// Depends on kbu_pkg, kbu_in_if and the assertion macro header.
`include "kmeans_bound_update_unit_defines.svh"

module kbu_front #(
	parameter int MAX_CLUSTERS = kbu_pkg::MAX_CLUSTERS_DEF,
	parameter int VALUE_WIDTH  = kbu_pkg::VALUE_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	kbu_in_if.sink                      cmd,
	input  logic                        cfg_we,
	input  logic [kbu_pkg::NCL_W-1:0]   cfg_wdata,
	output logic                        q_valid,
	input  logic                        q_ready,
	output kbu_pkg::kbu_ctl_t           q_ctl,
	output logic [VALUE_WIDTH-1:0]      q_moved,
	output logic [VALUE_WIDTH-1:0]      q_upper,
	output logic [VALUE_WIDTH-1:0]      q_lower
);
	import kbu_pkg::*;

	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	logic [NCL_W-1:0]  num_clusters_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;

	kbu_ctl_t               ctl_q   [QUEUE_DEPTH];
	logic [VALUE_WIDTH-1:0] moved_q [QUEUE_DEPTH];
	logic [VALUE_WIDTH-1:0] upper_q [QUEUE_DEPTH];
	logic [VALUE_WIDTH-1:0] lower_q [QUEUE_DEPTH];

	logic     idx_ok;
	logic     keep;
	logic     push;
	logic     pop;
	kbu_ctl_t ctl_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_clusters_q <= NUM_CLUSTERS_RST;
		end else if (cfg_we) begin
			num_clusters_q <= cfg_wdata;
		end
	end

	// A label must be below both the programmed count and the table depth.
	always_comb begin
		idx_ok = (NCL_W'(cmd.cluster_index) < num_clusters_q)
			&& (int'(cmd.cluster_index) < MAX_CLUSTERS);
		ctl_in.idx = cmd.cluster_index;
		if (cmd.operation == OP_LOAD) begin
			ctl_in.kind = CMD_LOAD;
		end else if (idx_ok) begin
			ctl_in.kind = CMD_UPDATE;
		end else begin
			ctl_in.kind = CMD_REJECT;
		end
		// Loads outside the valid range are accepted and dropped here.
		keep = (cmd.operation == OP_UPDATE) || idx_ok;
	end

	assign cmd.ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign push      = cmd.valid && cmd.ready && keep;
	assign pop       = q_valid && q_ready;
	assign q_valid   = (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ctl_q[wr_ptr_q]   <= ctl_in;
			moved_q[wr_ptr_q] <= VALUE_WIDTH'(cmd.moved_distance);
			upper_q[wr_ptr_q] <= VALUE_WIDTH'(cmd.upper_bound);
			lower_q[wr_ptr_q] <= VALUE_WIDTH'(cmd.lower_bound);
		end
	end

	assign q_ctl   = ctl_q[rd_ptr_q];
	assign q_moved = moved_q[rd_ptr_q];
	assign q_upper = upper_q[rd_ptr_q];
	assign q_lower = lower_q[rd_ptr_q];

	`KBU_ASSERT_IMPL(a_queue_bound, clk, arst_n, 1'b1, cnt_q <= QCNT_W'(QUEUE_DEPTH))
	`KBU_ASSERT_NEXT(a_queue_fill, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 1'b1)
endmodule

// ===== src/kbu_back.sv =====
// Back end: movement table, running largest/second-largest tracking and bound math.
// Depends on kbu_pkg, kbu_out_if, kbu_ram and the assertion macro header.
`include "kmeans_bound_update_unit_defines.svh"

module kbu_back #(
	parameter int MAX_CLUSTERS = kbu_pkg::MAX_CLUSTERS_DEF,
	parameter int VALUE_WIDTH  = kbu_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	output logic                   q_ready,
	input  kbu_pkg::kbu_ctl_t      q_ctl,
	input  logic [VALUE_WIDTH-1:0] q_moved,
	input  logic [VALUE_WIDTH-1:0] q_upper,
	input  logic [VALUE_WIDTH-1:0] q_lower,
	kbu_out_if.source              res
);
	import kbu_pkg::*;

	localparam int ADDR_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;

	logic [VALUE_WIDTH-1:0] largest_q;
	logic [VALUE_WIDTH-1:0] second_q;
	logic [IDX_W_IN-1:0]    largest_idx_q;

	logic                   valid_s1;
	logic                   err_s1;
	logic [VALUE_WIDTH-1:0] upper_s1;
	logic [VALUE_WIDTH-1:0] lower_s1;
	logic [VALUE_WIDTH-1:0] sub_s1;

	logic                   res_valid_q;
	logic [FIELD_W-1:0]     new_upper_q;
	logic [FIELD_W-1:0]     new_lower_q;
	logic                   label_error_q;

	logic                   is_load;
	logic                   do_load;
	logic                   do_point;
	logic                   s1_free;
	logic                   s2_adv;
	logic [ADDR_W-1:0]      addr;
	logic [VALUE_WIDTH-1:0] own_move;
	logic [VALUE_WIDTH-1:0] base_l;
	logic [VALUE_WIDTH-1:0] base_s;
	logic [VALUE_WIDTH-1:0] next_l;
	logic [VALUE_WIDTH-1:0] next_s;
	logic [IDX_W_IN-1:0]    next_idx;
	logic [VALUE_WIDTH-1:0] sub_move;
	logic [VALUE_WIDTH:0]   sum;
	logic [VALUE_WIDTH-1:0] nu;
	logic [VALUE_WIDTH-1:0] nl;

	assign is_load  = (q_ctl.kind == CMD_LOAD);
	assign s2_adv   = valid_s1 && (!res_valid_q || res.ready);
	assign s1_free  = !valid_s1 || s2_adv;
	// Loads are always accepted from the queue; point transactions wait for room in the read stage.
	assign q_ready  = is_load || s1_free;
	assign do_load  = q_valid && is_load;
	assign do_point = q_valid && !is_load && s1_free;
	assign addr     = ADDR_W'(q_ctl.idx);

	kbu_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (MAX_CLUSTERS)
	) u_table (
		.clk   (clk),
		.we    (do_load),
		.waddr (addr),
		.wdata (q_moved),
		.re    (do_point && (q_ctl.kind == CMD_UPDATE)),
		.raddr (addr),
		.rdata (own_move)
	);

	// A load at cluster zero starts a fresh pass, so the tracking restarts from zero.
	always_comb begin
		if (q_ctl.idx == '0) begin
			base_l   = '0;
			base_s   = '0;
			next_idx = '0;
		end else begin
			base_l   = largest_q;
			base_s   = second_q;
			next_idx = largest_idx_q;
		end
		next_l = base_l;
		next_s = base_s;
		if (base_l <= q_moved) begin
			next_s   = base_l;
			next_l   = q_moved;
			next_idx = q_ctl.idx;
		end else if (base_s <= q_moved) begin
			next_s = q_moved;
		end
		sub_move = (q_ctl.idx == largest_idx_q) ? second_q : largest_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			largest_q     <= '0;
			second_q      <= '0;
			largest_idx_q <= '0;
		end else if (do_load) begin
			largest_q     <= next_l;
			second_q      <= next_s;
			largest_idx_q <= next_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= do_point;
		end
	end

	always_ff @(posedge clk) begin
		if (do_point) begin
			err_s1   <= (q_ctl.kind == CMD_REJECT);
			upper_s1 <= q_upper;
			lower_s1 <= q_lower;
			sub_s1   <= sub_move;
		end
	end

	always_comb begin
		sum = {1'b0, upper_s1} + {1'b0, own_move};
		if (err_s1) begin
			nu = upper_s1;
			nl = lower_s1;
		end else begin
			nu = sum[VALUE_WIDTH] ? '1 : sum[VALUE_WIDTH-1:0];
			nl = (lower_s1 >= sub_s1) ? lower_s1 - sub_s1 : sub_s1 - lower_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s2_adv) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			new_upper_q   <= FIELD_W'(nu);
			new_lower_q   <= FIELD_W'(nl);
			label_error_q <= err_s1;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.new_upper   = new_upper_q;
	assign res.new_lower   = new_lower_q;
	assign res.label_error = label_error_q;

	`KBU_ASSERT_IMPL(a_track_order, clk, arst_n, 1'b1, second_q <= largest_q)
	`KBU_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && res_valid_q && !res.ready, valid_s1 && $stable(upper_s1) && $stable(sub_s1))
endmodule
